/* sv/afsk_pkg.sv */
// Shared types and constants for the AFSK half-cycle bit decoder.
// No dependencies; used by afsk_window and afsk_half_cycle_bit_decoder.
`timescale 1ns / 1ps

package afsk_pkg;

    // configuration register width and default time stamp width
    localparam int CFG_WIDTH        = 24;
    localparam int TIME_WIDTH_DEF   = 48;
    localparam int CFG_ADDR_WIDTH   = 2;

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_SPACE_HALF_LEN  = 2'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_SPACE_TOLERANCE = 2'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_MARK_HALF_LEN   = 2'd2;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_MARK_TOLERANCE  = 2'd3;

    // register reset values
    localparam logic [CFG_WIDTH-1:0] SPACE_HALF_LEN_RST  = 24'd124;
    localparam logic [CFG_WIDTH-1:0] SPACE_TOLERANCE_RST = 24'd49;
    localparam logic [CFG_WIDTH-1:0] MARK_HALF_LEN_RST   = 24'd249;
    localparam logic [CFG_WIDTH-1:0] MARK_TOLERANCE_RST  = 24'd99;

    // class of the most recent half-cycle
    typedef enum logic [2:0] {
        CLS_IDLE  = 3'd0,
        CLS_SPACE = 3'd1,
        CLS_MARK  = 3'd2,
        CLS_BAD   = 3'd3,
        CLS_USED  = 3'd4
    } half_class_t;

    // kind of result beat
    typedef enum logic [1:0] {
        KIND_BIT   = 2'd0,
        KIND_BAD   = 2'd1,
        KIND_PHASE = 2'd2
    } event_kind_t;

endpackage

/* sv/afsk_half_cycle_bit_decoder.sv */
// Top level of the AFSK half-cycle bit decoder: edge stream in, bit and error stream out.
// Depends on afsk_pkg and afsk_window.
`timescale 1ns / 1ps
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+-------------------------------------------
//  s_axis    | s_axis_tvalid / s_axis_tready| tdata: edge_time
//  m_axis    | m_axis_tvalid / m_axis_tready| tdata: bit_value, span_start, span_end;
//            |                              | tuser: event_kind
//  cfg       | cfg_we                       | cfg_addr, cfg_wdata
//
//  One edge beat per cycle while m_axis does not stall; a result is offered on m_axis once its edge
//  has waited in the input register and the subtract and compares have loaded the output register.
//  Edges that give no result leave no beat on m_axis.
//  Stalls on m_axis hold the output register and back up through the input register.
//  rst_n clears valid flags, edge history, class state and the registers to defaults.

module afsk_half_cycle_bit_decoder
    import afsk_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // edge_time
    input  logic [((TIME_WIDTH + 7) / 8) * 8 - 1:0]          s_axis_tdata,

    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // bit_value, span_start, span_end
    output logic [((1 + 2 * TIME_WIDTH + 7) / 8) * 8 - 1:0]  m_axis_tdata,
    // event_kind
    output logic [1:0]                m_axis_tuser,

    input  logic                      cfg_we,
    input  logic [CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  logic [CFG_WIDTH-1:0]      cfg_wdata
);

    localparam int OUT_BITS       = 1 + 2 * TIME_WIDTH;
    localparam int OUT_DATA_WIDTH = ((OUT_BITS + 7) / 8) * 8;

    // configuration registers
    logic [CFG_WIDTH-1:0] space_half_len_reg;
    logic [CFG_WIDTH-1:0] space_tolerance_reg;
    logic [CFG_WIDTH-1:0] mark_half_len_reg;
    logic [CFG_WIDTH-1:0] mark_tolerance_reg;

    // input register
    logic                  in_valid_reg;
    logic [TIME_WIDTH-1:0] in_time_reg;

    // decoder state
    logic [TIME_WIDTH-1:0] last_edge_reg;
    logic [TIME_WIDTH-1:0] older_edge_reg;
    half_class_t           class_reg;
    half_class_t           class_next;

    // output register
    logic                  out_valid_reg;
    event_kind_t           out_kind_reg;
    logic                  out_bit_reg;
    logic [TIME_WIDTH-1:0] out_start_reg;
    logic [TIME_WIDTH-1:0] out_end_reg;

    logic                  out_valid_next;
    event_kind_t           out_kind_next;
    logic                  out_bit_next;
    logic [TIME_WIDTH-1:0] out_start_next;

    logic                  out_free;
    logic                  advance;
    logic [TIME_WIDTH-1:0] interval;
    logic                  space_hit;
    logic                  mark_hit;
    half_class_t           cur_class;

    // handshake chain
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    // configuration writes, unknown indexes fall through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            space_half_len_reg  <= SPACE_HALF_LEN_RST;
            space_tolerance_reg <= SPACE_TOLERANCE_RST;
            mark_half_len_reg   <= MARK_HALF_LEN_RST;
            mark_tolerance_reg  <= MARK_TOLERANCE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_SPACE_HALF_LEN:  space_half_len_reg  <= cfg_wdata;
                REG_SPACE_TOLERANCE: space_tolerance_reg <= cfg_wdata;
                REG_MARK_HALF_LEN:   mark_half_len_reg   <= cfg_wdata;
                REG_MARK_TOLERANCE:  mark_tolerance_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_time_reg <= s_axis_tdata[TIME_WIDTH-1:0];
        end
    end

    // interval since previous edge, wraps naturally
    assign interval = in_time_reg - last_edge_reg;

    afsk_window #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_space_window (
        .len    (interval),
        .centre (space_half_len_reg),
        .tol    (space_tolerance_reg),
        .hit    (space_hit)
    );

    afsk_window #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_mark_window (
        .len    (interval),
        .centre (mark_half_len_reg),
        .tol    (mark_tolerance_reg),
        .hit    (mark_hit)
    );

    // classify, space takes priority
    always_comb
    begin
        if (space_hit)
            cur_class = CLS_SPACE;
        else if (mark_hit)
            cur_class = CLS_MARK;
        else
            cur_class = CLS_BAD;
    end

    // result selection and next class
    always_comb
    begin
        class_next     = cur_class;
        out_valid_next = 1'b0;
        out_kind_next  = KIND_BIT;
        out_bit_next   = 1'b0;
        out_start_next = last_edge_reg;
        if (cur_class != CLS_BAD && class_reg == cur_class)
        begin
            // pair of equal half-cycles gives a bit
            out_valid_next = 1'b1;
            out_bit_next   = (cur_class == CLS_MARK);
            out_start_next = older_edge_reg;
            class_next     = CLS_USED;
        end
        else if (cur_class == CLS_BAD)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = KIND_BAD;
        end
        else if ((cur_class == CLS_SPACE && class_reg == CLS_MARK) ||
                 (cur_class == CLS_MARK && class_reg == CLS_SPACE))
        begin
            out_valid_next = 1'b1;
            out_kind_next  = KIND_PHASE;
        end
    end

    // edge history and class state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_edge_reg  <= '0;
            older_edge_reg <= '0;
            class_reg      <= CLS_IDLE;
        end
        else if (advance)
        begin
            older_edge_reg <= last_edge_reg;
            last_edge_reg  <= in_time_reg;
            class_reg      <= class_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_kind_reg  <= out_kind_next;
            out_bit_reg   <= out_bit_next;
            out_start_reg <= out_start_next;
            out_end_reg   <= in_time_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = OUT_DATA_WIDTH'({out_end_reg, out_start_reg, out_bit_reg});

endmodule

/* sv/afsk_window.sv */
// Window test: interval within centre plus or minus tolerance, no wrap.
// Depends on afsk_pkg for the register width.
`timescale 1ns / 1ps

module afsk_window
    import afsk_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
)
(
    input  logic [TIME_WIDTH-1:0] len,
    input  logic [CFG_WIDTH-1:0]  centre,
    input  logic [CFG_WIDTH-1:0]  tol,
    output logic                  hit
);

    localparam int CMP_WIDTH = (TIME_WIDTH > CFG_WIDTH + 1) ? TIME_WIDTH : CFG_WIDTH + 1;

    logic [CFG_WIDTH:0]   hi_sum;
    logic [CFG_WIDTH-1:0] lo_bound;
    logic [CMP_WIDTH-1:0] len_x;
    logic [CMP_WIDTH-1:0] lo_x;
    logic [CMP_WIDTH-1:0] hi_x;

    // bounds, lower edge clamped at zero
    assign hi_sum   = {1'b0, centre} + {1'b0, tol};
    assign lo_bound = (centre > tol) ? (centre - tol) : '0;

    assign len_x = CMP_WIDTH'(len);
    assign lo_x  = CMP_WIDTH'(lo_bound);
    assign hi_x  = CMP_WIDTH'(hi_sum);

    assign hit = (len_x >= lo_x) && (len_x <= hi_x);

endmodule
